[rtl/core/preset_countdown_timer_control_assert.svh]
// Assertion macros for the preset countdown timer control.
`ifndef PRESET_COUNTDOWN_TIMER_CONTROL_ASSERT_SVH
`define PRESET_COUNTDOWN_TIMER_CONTROL_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PCTC_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/pctc_pkg.sv]
// Package with types, codes and helpers of the preset countdown timer control.
package pctc_pkg;

   localparam int PRESET_COUNT = 5;
   localparam int SEL_W        = 3;
   localparam int IDX_W        = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;

   localparam logic [4:0] HOUR_MAX = 5'd23;
   localparam logic [5:0] MIN_MAX  = 6'd59;
   localparam logic [5:0] SEC_MAX  = 6'd59;
   localparam logic [7:0] AGE_MAX  = 8'd255;
   localparam logic [7:0] LONG_PRESS_RESET = 8'd16;

   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [2:0] KEY_NONE   = 3'd0;
   localparam logic [2:0] KEY_SELECT = 3'd1;
   localparam logic [2:0] KEY_FIELD  = 3'd2;
   localparam logic [2:0] KEY_INC    = 3'd3;
   localparam logic [2:0] KEY_START  = 3'd4;

   localparam logic [2:0] CODE_STANDBY = 3'd0;
   localparam logic [2:0] CODE_HOUR    = 3'd1;
   localparam logic [2:0] CODE_MIN     = 3'd2;
   localparam logic [2:0] CODE_SEC     = 3'd3;
   localparam logic [2:0] CODE_RUN     = 3'd4;
   localparam logic [2:0] CODE_PAUSE   = 3'd5;

   typedef enum logic [5:0] {
      MODE_STANDBY = 6'b000001,
      MODE_HOUR    = 6'b000010,
      MODE_MIN     = 6'b000100,
      MODE_SEC     = 6'b001000,
      MODE_RUN     = 6'b010000,
      MODE_PAUSE   = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } preset_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_STANDBY: c = CODE_STANDBY;
         MODE_HOUR:    c = CODE_HOUR;
         MODE_MIN:     c = CODE_MIN;
         MODE_SEC:     c = CODE_SEC;
         MODE_RUN:     c = CODE_RUN;
         MODE_PAUSE:   c = CODE_PAUSE;
         default:      c = CODE_STANDBY;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/preset_countdown_timer_control.sv]
// Top level of the preset countdown timer control: key decoding, presets and countdown.
//
// The block takes one item per clock: a key-scan sample (req_cmd low, req_key_code 0..7)
// or a one-second tick (req_cmd high). Every item yields exactly one result item showing
// mode, selected preset, time, LED and armed flag after that item. The whole update is one
// short pass of logic from the state registers into the state and result registers, so the
// result appears on rsp_ the cycle after acceptance, and a new item is taken every cycle as
// long as the result register is empty or being drained in the same cycle (req_ready follows
// rsp_ready combinationally). The long-press threshold is written through the csr_ port,
// which is always ready; write it only while the block is idle. There is no clearing pass:
// presets reset to zero at once.
module preset_countdown_timer_control (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_long_press_scans,
   // input items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [2:0]             req_key_code,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_mode,
   output logic [pctc_pkg::SEL_W-1:0] rsp_preset_number,
   output logic [4:0]             rsp_hours,
   output logic [5:0]             rsp_minutes,
   output logic [5:0]             rsp_seconds,
   output logic                   rsp_led_on,
   output logic                   rsp_armed
);
   import pctc_pkg::*;

   `include "preset_countdown_timer_control_assert.svh"

   // State registers
   logic [7:0]       long_press_ff;
   mode_type         mode_ff, mode_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic [4:0]       hour_ff, hour_in;
   logic [5:0]       min_ff, min_in;
   logic [5:0]       sec_ff, sec_in;
   logic             armed_ff, armed_in;
   logic [2:0]       prev_key_ff, prev_key_in;
   logic [7:0]       age_ff, age_in;
   logic             led_ff, led_in;
   preset_type       store_ff [PRESET_COUNT];

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_mode_ff;
   logic [SEL_W-1:0] rsp_sel_ff;
   logic [4:0]       rsp_hour_ff;
   logic [5:0]       rsp_min_ff;
   logic [5:0]       rsp_sec_ff;
   logic             rsp_led_ff;
   logic             rsp_armed_ff;

   logic             req_accept;
   logic             store_wr_en;
   logic [IDX_W-1:0] store_wr_idx;
   logic [IDX_W-1:0] store_rd_idx;
   logic [SEL_W-1:0] sel_next;
   preset_type       store_rd;
   logic [2:0]       diff, down, up;
   logic [4:0]       hour_bump;
   logic [5:0]       min_bump;
   logic [5:0]       sec_bump;
   logic             set_mode;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Wrapping increments of the field being set
   assign hour_bump = (hour_ff >= HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
   assign min_bump  = (min_ff  >= MIN_MAX)  ? 6'd0 : min_ff  + 6'd1;
   assign sec_bump  = (sec_ff  >= SEC_MAX)  ? 6'd0 : sec_ff  + 6'd1;

   assign set_mode = (mode_ff == MODE_HOUR) || (mode_ff == MODE_MIN) || (mode_ff == MODE_SEC);

   // Next preset slot on a select key; wrap back to the first slot
   assign sel_next = (sel_ff >= SEL_W'(PRESET_COUNT)) ? SEL_W'(1) : sel_ff + SEL_W'(1);
   assign store_rd_idx = IDX_W'(sel_next - SEL_W'(1));
   assign store_rd     = store_ff[store_rd_idx];
   assign store_wr_idx = IDX_W'(sel_ff - SEL_W'(1));

   // Edge detection on the raw key codes
   assign diff = prev_key_ff ^ req_key_code;
   assign down = req_key_code & diff;
   assign up   = ~req_key_code & diff;

   always_comb begin
      mode_in     = mode_ff;
      sel_in      = sel_ff;
      hour_in     = hour_ff;
      min_in      = min_ff;
      sec_in      = sec_ff;
      armed_in    = armed_ff;
      prev_key_in = prev_key_ff;
      age_in      = age_ff;
      led_in      = led_ff;
      store_wr_en = 1'b0;

      if (req_accept) begin
         if (req_cmd == CMD_SCAN) begin
            prev_key_in = req_key_code;
            // restart the press age on a new press, else age it up to saturation
            if (down != 3'd0) begin
               age_in = 8'd0;
            end else if (age_ff != AGE_MAX) begin
               age_in = age_ff + 8'd1;
            end

            if (age_in <= long_press_ff) begin
               // short press: act on the released key
               case (up)
                  KEY_SELECT: begin
                     if (mode_ff == MODE_STANDBY) begin
                        sel_in  = sel_next;
                        hour_in = store_rd.hours;
                        min_in  = store_rd.minutes;
                        sec_in  = store_rd.seconds;
                     end
                  end
                  KEY_FIELD: begin
                     armed_in = 1'b0;
                     case (mode_ff)
                        MODE_STANDBY: mode_in = MODE_HOUR;
                        MODE_HOUR:    mode_in = MODE_MIN;
                        MODE_MIN:     mode_in = MODE_SEC;
                        MODE_SEC:     mode_in = MODE_HOUR;
                        default:      mode_in = mode_ff;
                     endcase
                  end
                  KEY_INC: begin
                     if (mode_ff == MODE_HOUR) hour_in = hour_bump;
                     if (mode_ff == MODE_MIN)  min_in  = min_bump;
                     if (mode_ff == MODE_SEC)  sec_in  = sec_bump;
                  end
                  KEY_START: begin
                     if (armed_ff) begin
                        mode_in = (mode_ff != MODE_RUN) ? MODE_RUN : MODE_PAUSE;
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               // long press: act on the held key at every scan
               case (req_key_code)
                  KEY_FIELD: begin
                     if (set_mode) begin
                        store_wr_en = 1'b1;
                        mode_in     = MODE_STANDBY;
                        armed_in    = 1'b1;
                     end
                  end
                  KEY_INC: begin
                     if (mode_ff == MODE_HOUR) hour_in = hour_bump;
                     if (mode_ff == MODE_MIN)  min_in  = min_bump;
                     if (mode_ff == MODE_SEC)  sec_in  = sec_bump;
                  end
                  KEY_START: begin
                     if (mode_ff inside {MODE_RUN, MODE_PAUSE}) begin
                        mode_in = MODE_STANDBY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            // tick: count down with borrow, hold at zero, blink while running
            if (mode_ff == MODE_RUN) begin
               led_in = !led_ff;
               if (sec_ff != 6'd0) begin
                  sec_in = sec_ff - 6'd1;
               end else if (min_ff != 6'd0) begin
                  min_in = min_ff - 6'd1;
                  sec_in = SEC_MAX;
               end else if (hour_ff != 5'd0) begin
                  hour_in = hour_ff - 5'd1;
                  min_in  = MIN_MAX;
                  sec_in  = SEC_MAX;
               end
            end else begin
               led_in = 1'b0;
            end
         end
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         mode_ff       <= MODE_STANDBY;
         sel_ff        <= SEL_W'(1);
         hour_ff       <= '0;
         min_ff        <= '0;
         sec_ff        <= '0;
         armed_ff      <= 1'b0;
         prev_key_ff   <= KEY_NONE;
         age_ff        <= AGE_MAX;
         led_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < PRESET_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            long_press_ff <= csr_long_press_scans;
         end
         mode_ff      <= mode_in;
         sel_ff       <= sel_in;
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         armed_ff     <= armed_in;
         prev_key_ff  <= prev_key_in;
         age_ff       <= age_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_wr_en) begin
            store_ff[store_wr_idx] <= '{hours: hour_ff, minutes: min_ff, seconds: sec_ff};
         end
      end
   end

   // Capture the state after the item into the result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_mode_ff  <= mode_code(mode_in);
         rsp_sel_ff   <= sel_in;
         rsp_hour_ff  <= hour_in;
         rsp_min_ff   <= min_in;
         rsp_sec_ff   <= sec_in;
         rsp_led_ff   <= led_in;
         rsp_armed_ff <= armed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_preset_number = rsp_sel_ff;
   assign rsp_hours         = rsp_hour_ff;
   assign rsp_minutes       = rsp_min_ff;
   assign rsp_seconds       = rsp_sec_ff;
   assign rsp_led_on        = rsp_led_ff;
   assign rsp_armed         = rsp_armed_ff;

   // Selected slot always names a real preset
   `PCTC_ASSERT_ALWAYS(a_sel_range, clock, reset,
      (sel_ff != '0) && (sel_ff <= SEL_W'(PRESET_COUNT)))
   // Time fields never leave their clock ranges
   `PCTC_ASSERT_ALWAYS(a_time_range, clock, reset,
      (hour_ff <= HOUR_MAX) && (min_ff <= MIN_MAX) && (sec_ff <= SEC_MAX))
   // An accepted item always leaves a result behind
   `PCTC_ASSERT_NEXT(a_accept_result, clock, reset, req_accept, rsp_valid_ff)
   // A tick outside running switches the LED off
   `PCTC_ASSERT_NEXT(a_led_off, clock, reset,
      req_accept && (req_cmd == CMD_TICK) && (mode_ff != MODE_RUN), !led_ff)

endmodule

[dv/tb_preset_countdown_timer_control.sv]
// Self-checking testbench for the preset countdown timer control.
`timescale 1ns / 1ps

module tb_preset_countdown_timer_control;
   import pctc_pkg::*;

   // Time arithmetic of the countdown.
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   // Cycles to let pass once nothing is outstanding: the result lands in the cycle after the item.
   localparam int SETTLE_CYCLES = 4;
   // Give up on outstanding results after this many cycles of waiting.
   localparam int DRAIN_LIMIT   = 5000;
   // Longest run of idle cycles the sender inserts before one item.
   localparam int MAX_GAP       = 8;

   // One result item as the block shows it.
   typedef struct {
      logic [2:0] mode;
      logic [2:0] preset;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       led;
      logic       armed;
   } timer_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_long_press_scans = 8'd0;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = CMD_SCAN;
   logic [2:0] req_key_code = KEY_NONE;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_mode;
   logic [SEL_W-1:0] rsp_preset_number;
   logic [4:0]       rsp_hours;
   logic [5:0]       rsp_minutes;
   logic [5:0]       rsp_seconds;
   logic             rsp_led_on;
   logic             rsp_armed;

   // Idling profile, percent per cycle.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   int mismatch_count = 0;

   // Expected result items, oldest first.
   timer_view_type expected_views[$];

   // Timer state as predicted from the accepted items.
   logic [7:0] tm_long_limit;
   logic [2:0] tm_mode;
   logic [2:0] tm_sel;
   logic [4:0] tm_hours;
   logic [5:0] tm_minutes;
   logic [5:0] tm_seconds;
   logic       tm_armed;
   logic [2:0] tm_prev_key;
   logic [7:0] tm_age;
   logic       tm_led;
   preset_type tm_presets [PRESET_COUNT];

   preset_countdown_timer_control i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_long_press_scans (csr_long_press_scans),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_key_code         (req_key_code),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mode             (rsp_mode),
      .rsp_preset_number    (rsp_preset_number),
      .rsp_hours            (rsp_hours),
      .rsp_minutes          (rsp_minutes),
      .rsp_seconds          (rsp_seconds),
      .rsp_led_on           (rsp_led_on),
      .rsp_armed            (rsp_armed)
   );

   // 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: stall at random, re-decided on every falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------------------------
   // Timer prediction
   // ---------------------------------------------------------------------------------------

   task automatic clear_timer_state();
      tm_long_limit = LONG_PRESS_RESET;
      tm_mode       = CODE_STANDBY;
      tm_sel        = 3'd1;
      tm_hours      = '0;
      tm_minutes    = '0;
      tm_seconds    = '0;
      tm_armed      = 1'b0;
      tm_prev_key   = KEY_NONE;
      tm_age        = AGE_MAX;
      tm_led        = 1'b1;
      foreach (tm_presets[i]) tm_presets[i] = '0;
   endtask

   // Selected preset slot; fall back to the first one outside the legal range.
   function automatic int preset_slot();
      return (tm_sel >= 1 && tm_sel <= PRESET_COUNT) ? int'(tm_sel) - 1 : 0;
   endfunction

   // Step the field being set, wrapping at its maximum.
   function automatic void bump_field();
      case (tm_mode)
         CODE_HOUR: tm_hours   = (tm_hours >= HOUR_MAX) ? 5'd0 : tm_hours + 5'd1;
         CODE_MIN:  tm_minutes = (tm_minutes >= MIN_MAX) ? 6'd0 : tm_minutes + 6'd1;
         CODE_SEC:  tm_seconds = (tm_seconds >= SEC_MAX) ? 6'd0 : tm_seconds + 6'd1;
         default: ;
      endcase
   endfunction

   // Apply one accepted item to the predicted state and queue the result it causes.
   function automatic void advance_timer(input logic cmd, input logic [2:0] key);
      logic [2:0]     changed;
      logic [2:0]     pressed;
      logic [2:0]     released;
      int             remaining;
      timer_view_type view;
      if (cmd == CMD_SCAN) begin
         changed     = tm_prev_key ^ key;
         pressed     = key & changed;
         released    = ~key & changed;
         tm_prev_key = key;
         if (pressed != KEY_NONE) begin
            tm_age = 8'd0;
         end else if (tm_age != AGE_MAX) begin
            tm_age = tm_age + 8'd1;
         end
         if (tm_age <= tm_long_limit) begin
            // short press: act on the released code
            case (released)
               KEY_SELECT: begin
                  if (tm_mode == CODE_STANDBY) begin
                     tm_sel = (tm_sel >= PRESET_COUNT) ? 3'd1 : tm_sel + 3'd1;
                     {tm_hours, tm_minutes, tm_seconds} = tm_presets[preset_slot()];
                  end
               end
               KEY_FIELD: begin
                  tm_armed = 1'b0;
                  if (tm_mode == CODE_STANDBY) begin
                     tm_mode = CODE_HOUR;
                  end else if (tm_mode < CODE_RUN) begin
                     tm_mode = (tm_mode >= CODE_SEC) ? CODE_HOUR : tm_mode + 3'd1;
                  end
               end
               KEY_INC: bump_field();
               KEY_START: begin
                  if (tm_armed) tm_mode = (tm_mode != CODE_RUN) ? CODE_RUN : CODE_PAUSE;
               end
               default: ;
            endcase
         end else begin
            // long press: act on the held code at every scan
            case (key)
               KEY_FIELD: begin
                  if (tm_mode >= CODE_HOUR && tm_mode <= CODE_SEC) begin
                     tm_presets[preset_slot()] = {tm_hours, tm_minutes, tm_seconds};
                     tm_mode  = CODE_STANDBY;
                     tm_armed = 1'b1;
                  end
               end
               KEY_INC: bump_field();
               KEY_START: begin
                  if (tm_mode == CODE_RUN || tm_mode == CODE_PAUSE) tm_mode = CODE_STANDBY;
               end
               default: ;
            endcase
         end
      end else if (tm_mode == CODE_RUN) begin
         // count down one second, holding at zero
         remaining = int'(tm_hours) * SECS_PER_HOUR + int'(tm_minutes) * SECS_PER_MIN
                     + int'(tm_seconds);
         if (remaining > 0) remaining--;
         tm_hours   = 5'(remaining / SECS_PER_HOUR);
         tm_minutes = 6'((remaining % SECS_PER_HOUR) / SECS_PER_MIN);
         tm_seconds = 6'((remaining % SECS_PER_HOUR) % SECS_PER_MIN);
         tm_led     = ~tm_led;
      end else begin
         tm_led = 1'b0;
      end
      view.mode    = tm_mode;
      view.preset  = tm_sel;
      view.hours   = tm_hours;
      view.minutes = tm_minutes;
      view.seconds = tm_seconds;
      view.led     = tm_led;
      view.armed   = tm_armed;
      expected_views.push_back(view);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Compare every result item taken from the block against the oldest expectation.
   always @(posedge clock) begin : check_results
      timer_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_views.size() == 0) begin
            report_mismatch("unexpected result item", 1, 0);
         end else begin
            want = expected_views.pop_front();
            if (rsp_mode !== want.mode) report_mismatch("mode", rsp_mode, want.mode);
            if (rsp_preset_number !== want.preset)
               report_mismatch("preset_number", rsp_preset_number, want.preset);
            if (rsp_hours !== want.hours) report_mismatch("hours", rsp_hours, want.hours);
            if (rsp_minutes !== want.minutes)
               report_mismatch("minutes", rsp_minutes, want.minutes);
            if (rsp_seconds !== want.seconds)
               report_mismatch("seconds", rsp_seconds, want.seconds);
            if (rsp_led_on !== want.led) report_mismatch("led_on", rsp_led_on, want.led);
            if (rsp_armed !== want.armed) report_mismatch("armed", rsp_armed, want.armed);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   // Send one item: idle for a random gap, then hold valid and payload until taken.
   // Valid stays high on return so back-to-back items never drop it within one step.
   task automatic send_item(input logic cmd, input logic [2:0] key);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_key_code <= key;
      do @(posedge clock); while (!req_ready);
      advance_timer(cmd, key);
   endtask

   // Hold a key for a number of scans, then release it with one empty scan.
   task automatic press_key(input logic [2:0] key, input int scans);
      repeat (scans) send_item(CMD_SCAN, key);
      send_item(CMD_SCAN, KEY_NONE);
   endtask

   // Drop valid and wait until every result item has come back, then let the block settle.
   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_views.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_views.size() != 0) begin
         report_mismatch("result items never delivered", 0, expected_views.size());
         expected_views.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the long-press threshold; only called while the block is idle.
   task automatic write_long_press(input logic [7:0] scans);
      @(negedge clock);
      csr_valid            <= 1'b1;
      csr_long_press_scans <= scans;
      do @(posedge clock); while (!csr_ready);
      tm_long_limit = scans;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // LED shows its reset value until the first tick; a tick outside running turns it off.
   task automatic test_power_up_view();
      send_item(CMD_SCAN, KEY_NONE);
      send_item(CMD_TICK, KEY_NONE);
   endtask

   // Select a preset, try to start unarmed, enter set mode and save with a long press.
   task automatic test_select_and_save();
      press_key(KEY_SELECT, 1);
      press_key(KEY_START, 1);
      press_key(KEY_FIELD, 1);
      press_key(KEY_FIELD, int'(tm_long_limit) + 2);
   endtask

   // Start at zero time: ticks hold the count at zero; pause, then stop with a long press.
   task automatic test_run_pause_stop();
      press_key(KEY_START, 1);
      send_item(CMD_TICK, KEY_NONE);
      send_item(CMD_TICK, KEY_NONE);
      press_key(KEY_START, 1);
      send_item(CMD_TICK, KEY_NONE);
      press_key(KEY_START, int'(tm_long_limit) + 2);
   endtask

   // Codes outside 1..4 still take part in the bitwise edge detection.
   task automatic test_unknown_codes();
      send_item(CMD_SCAN, 3'd5);
      send_item(CMD_SCAN, 3'd7);
      send_item(CMD_SCAN, KEY_INC);
      send_item(CMD_SCAN, KEY_SELECT);
      send_item(CMD_SCAN, KEY_NONE);
   endtask

   // Mostly whole presses of random keys and lengths, with ticks mixed in, plus raw noise.
   task automatic test_random_presses(input int n_items, input int long_pct);
      int         sent;
      int         pick;
      int         hold;
      int         cap;
      int         rest;
      logic [2:0] key;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_item(1'($urandom_range(1, 0)), 3'($urandom_range(7, 0)));
            sent++;
         end else if (pick < 30) begin
            repeat ($urandom_range(3, 1)) begin
               send_item(CMD_TICK, KEY_NONE);
               sent++;
            end
         end else begin
            key = 3'($urandom_range(int'(KEY_START), int'(KEY_SELECT)));
            cap = (tm_long_limit < 1) ? 1 : ((tm_long_limit > 12) ? 12 : int'(tm_long_limit));
            if ($urandom_range(99) < long_pct) begin
               hold = int'(tm_long_limit) + 1 + $urandom_range(24, 1);
            end else begin
               hold = $urandom_range(cap, 1);
            end
            repeat (hold) begin
               // ticks do not disturb the press timing
               if ($urandom_range(99) < 8) begin
                  send_item(CMD_TICK, KEY_NONE);
                  sent++;
               end
               send_item(CMD_SCAN, key);
               sent++;
            end
            rest = $urandom_range(3, 1);
            repeat (rest) send_item(CMD_SCAN, KEY_NONE);
            sent += rest;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      clear_timer_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the shortest useful window: one scan is short, three are long.
      set_idling(0, 0);
      write_long_press(8'd1);
      test_power_up_view();
      test_select_and_save();
      test_run_pause_stop();
      test_unknown_codes();
      wait_drained();

      // Random part: vary the window and the idling per phase.
      write_long_press(8'd3);
      test_random_presses(120, 30);
      wait_drained();

      set_idling(69, 0);
      write_long_press(8'd1);
      test_random_presses(100, 30);
      wait_drained();

      // Widest window below saturation: every press here stays short.
      set_idling(0, 69);
      write_long_press(8'd254);
      test_random_presses(80, 0);
      wait_drained();

      // Zero window: a press turns long on its second scan.
      set_idling(28, 28);
      write_long_press(8'd0);
      test_random_presses(80, 20);
      wait_drained();

      // Saturated window: presses can never turn long.
      set_idling(0, 0);
      write_long_press(8'd255);
      test_random_presses(70, 0);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("preset_countdown_timer_control verification clean");
      end else begin
         $display("preset_countdown_timer_control verification failed");
      end
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin
      #1000000;
      $display("preset_countdown_timer_control verification failed");
      $finish;
   end

endmodule
